### rtl/core/lpr_pkg.sv
package lpr_pkg;

    // Coordinate width of the line endpoints
    localparam int COORD_BITS_DEFAULT = 7;

    // Result field widths
    localparam int PIXEL_X_BITS    = 7;
    localparam int PIXEL_Y_BITS    = 6;
    localparam int BYTE_INDEX_BITS = 10;
    localparam int BIT_NUMBER_BITS = 3;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] RESET_SCREEN_WIDTH  = 7'd84;
    localparam logic [CFG_DATA_BITS-1:0] RESET_SCREEN_HEIGHT = 7'd48;

    // Tallest screen the frame-buffer addressing covers
    localparam logic [CFG_DATA_BITS-1:0] MAX_SCREEN_HEIGHT = 7'd64;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Walker status handed to the output stage
    typedef struct packed {
        logic fire;   // a pixel is produced by this transfer
        logic last;   // that pixel ends the line
    } step_ctl_t;

endpackage

### rtl/core/lpr_req_if.sv
interface lpr_req_if #(
    parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (
        output valid, cmd, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, cmd, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

### rtl/core/lpr_pix_if.sv
interface lpr_pix_if;
    logic                                valid;
    logic                                ready;
    logic [lpr_pkg::PIXEL_X_BITS-1:0]    pixel_x;
    logic [lpr_pkg::PIXEL_Y_BITS-1:0]    pixel_y;
    logic [lpr_pkg::BYTE_INDEX_BITS-1:0] byte_index;
    logic [lpr_pkg::BIT_NUMBER_BITS-1:0] bit_number;
    logic                                last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, byte_index, bit_number, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, byte_index, bit_number, last_pixel,
        output ready
    );
endinterface

### rtl/core/lpr_walker.sv
module lpr_walker #(
    parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  cmd,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] cur_x,
    output logic [COORD_BITS-1:0] cur_y,
    output lpr_pkg::step_ctl_t    ctl
);
    import lpr_pkg::*;

    // Error term holds -2*span .. 2*span, signed
    localparam int ERR_BITS = COORD_BITS + 3;
    localparam int EXT_BITS = ERR_BITS - COORD_BITS;

    logic [COORD_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]      stop_x_reg, stop_x_next;
    logic [COORD_BITS-1:0]      stop_y_reg, stop_y_next;
    logic [COORD_BITS-1:0]      span_x_reg, span_x_next;
    logic [COORD_BITS-1:0]      span_y_reg, span_y_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic                       dir_x_neg_reg, dir_x_neg_next;
    logic                       dir_y_neg_reg, dir_y_neg_next;
    logic                       x_major_reg, x_major_next;
    logic                       busy_reg, busy_next;

    // Load-side values
    logic                  ld_dir_x_neg;
    logic                  ld_dir_y_neg;
    logic [COORD_BITS-1:0] ld_span_x;
    logic [COORD_BITS-1:0] ld_span_y;
    logic                  ld_x_major;
    logic [COORD_BITS-1:0] ld_major;

    // Step-side values
    logic [COORD_BITS-1:0]      major_span;
    logic [COORD_BITS-1:0]      minor_span;
    logic signed [ERR_BITS-1:0] err_sum;
    logic                       minor_move;
    logic [COORD_BITS-1:0]      step_x;
    logic [COORD_BITS-1:0]      step_y;
    logic                       step_busy;
    logic                       do_step;

    // Set up direction, spans and major axis from the endpoints
    always_comb
    begin
        ld_dir_x_neg = !(end_x > start_x);
        ld_dir_y_neg = !(end_y > start_y);
        ld_span_x    = ld_dir_x_neg ? start_x - end_x : end_x - start_x;
        ld_span_y    = ld_dir_y_neg ? start_y - end_y : end_y - start_y;
        ld_x_major   = ld_span_x > ld_span_y;
        ld_major     = ld_x_major ? ld_span_x : ld_span_y;
    end

    // One Bresenham step: add twice the minor span, maybe move on the minor axis
    always_comb
    begin
        major_span = x_major_reg ? span_x_reg : span_y_reg;
        minor_span = x_major_reg ? span_y_reg : span_x_reg;
        err_sum    = err_reg + $signed({{EXT_BITS{1'b0}}, minor_span} << 1);
        minor_move = err_sum > 0;
        step_x     = cur_x_reg;
        step_y     = cur_y_reg;
        if (x_major_reg || minor_move)
        begin
            step_x = dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        end
        if (!x_major_reg || minor_move)
        begin
            step_y = dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        end
        step_busy = x_major_reg ? (step_x != stop_x_reg) : (step_y != stop_y_reg);
    end

    assign do_step = accept && (cmd == CMD_STEP) && busy_reg;

    // Next state for load, step, or hold
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        stop_x_next    = stop_x_reg;
        stop_y_next    = stop_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        err_next       = err_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        x_major_next   = x_major_reg;
        busy_next      = busy_reg;
        if (accept && (cmd == CMD_LOAD))
        begin
            cur_x_next     = start_x;
            cur_y_next     = start_y;
            stop_x_next    = end_x;
            stop_y_next    = end_y;
            span_x_next    = ld_span_x;
            span_y_next    = ld_span_y;
            err_next       = -$signed({{EXT_BITS{1'b0}}, ld_major});
            dir_x_neg_next = ld_dir_x_neg;
            dir_y_neg_next = ld_dir_y_neg;
            x_major_next   = ld_x_major;
            busy_next      = ld_major != '0;
        end
        else if (do_step)
        begin
            cur_x_next = step_x;
            cur_y_next = step_y;
            err_next   = minor_move
                       ? err_sum - $signed({{EXT_BITS{1'b0}}, major_span} << 1)
                       : err_sum;
            busy_next  = step_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            stop_x_reg    <= '0;
            stop_y_reg    <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            err_reg       <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            x_major_reg   <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            stop_x_reg    <= stop_x_next;
            stop_y_reg    <= stop_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            err_reg       <= err_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            x_major_reg   <= x_major_next;
            busy_reg      <= busy_next;
        end
    end

    // The pixel emitted is the one before the step
    assign cur_x    = cur_x_reg;
    assign cur_y    = cur_y_reg;
    assign ctl.fire = do_step;
    assign ctl.last = !step_busy;
endmodule

### rtl/core/lpr_addr.sv
module lpr_addr #(
    parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEFAULT
) (
    input  logic [COORD_BITS-1:0]                cur_x,
    input  logic [COORD_BITS-1:0]                cur_y,
    input  logic [lpr_pkg::CFG_DATA_BITS-1:0]    screen_width,
    input  logic [lpr_pkg::CFG_DATA_BITS-1:0]    screen_height,
    output logic [lpr_pkg::PIXEL_X_BITS-1:0]     pixel_x,
    output logic [lpr_pkg::PIXEL_Y_BITS-1:0]     pixel_y,
    output logic [lpr_pkg::BYTE_INDEX_BITS-1:0]  byte_index,
    output logic [lpr_pkg::BIT_NUMBER_BITS-1:0]  bit_number
);
    import lpr_pkg::*;

    localparam int BPC_BITS  = CFG_DATA_BITS - 3;
    localparam int PROD_BITS = PIXEL_X_BITS + BPC_BITS;

    logic [CFG_DATA_BITS-1:0] lim_x;
    logic [CFG_DATA_BITS-1:0] height;
    logic [CFG_DATA_BITS-1:0] lim_y_full;
    logic [PIXEL_Y_BITS-1:0]  lim_y;
    logic [BPC_BITS-1:0]      bytes_per_col;
    logic [PROD_BITS-1:0]     col_base;
    logic [PROD_BITS-1:0]     addr_sum;

    // Clamp to the screen limits
    always_comb
    begin
        lim_x      = (screen_width == '0) ? '0 : screen_width - 1'b1;
        height     = (screen_height > MAX_SCREEN_HEIGHT) ? MAX_SCREEN_HEIGHT : screen_height;
        lim_y_full = (height == '0) ? '0 : height - 1'b1;
        lim_y      = lim_y_full[PIXEL_Y_BITS-1:0];
        pixel_x    = (cur_x > COORD_BITS'(lim_x)) ? lim_x : cur_x[PIXEL_X_BITS-1:0];
        pixel_y    = (cur_y > COORD_BITS'(lim_y)) ? lim_y : cur_y[PIXEL_Y_BITS-1:0];
    end

    // Column-major byte address: x * (height / 8) + y / 8
    always_comb
    begin
        bytes_per_col = height[CFG_DATA_BITS-1:3];
        col_base      = PROD_BITS'(pixel_x) * PROD_BITS'(bytes_per_col);
        addr_sum      = col_base + PROD_BITS'(pixel_y[PIXEL_Y_BITS-1:3]);
        byte_index    = addr_sum[BYTE_INDEX_BITS-1:0];
        bit_number    = pixel_y[BIT_NUMBER_BITS-1:0];
    end
endmodule

### rtl/core/lpr_out_stage.sv
module lpr_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpr_pkg::step_ctl_t                  ctl,
    input  logic [lpr_pkg::PIXEL_X_BITS-1:0]    pixel_x,
    input  logic [lpr_pkg::PIXEL_Y_BITS-1:0]    pixel_y,
    input  logic [lpr_pkg::BYTE_INDEX_BITS-1:0] byte_index,
    input  logic [lpr_pkg::BIT_NUMBER_BITS-1:0] bit_number,
    output logic                                in_ready,
    lpr_pix_if.source                           result
);
    import lpr_pkg::*;

    logic                       valid_reg, valid_next;
    logic [PIXEL_X_BITS-1:0]    pixel_x_reg;
    logic [PIXEL_Y_BITS-1:0]    pixel_y_reg;
    logic [BYTE_INDEX_BITS-1:0] byte_index_reg;
    logic [BIT_NUMBER_BITS-1:0] bit_number_reg;
    logic                       last_reg;

    // Take a new item when the slot is empty or drains in this cycle
    assign in_ready   = !valid_reg || result.ready;
    assign valid_next = ctl.fire || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the pixel payload on a step transfer
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            pixel_x_reg    <= pixel_x;
            pixel_y_reg    <= pixel_y;
            byte_index_reg <= byte_index;
            bit_number_reg <= bit_number;
            last_reg       <= ctl.last;
        end
    end

    assign result.valid      = valid_reg;
    assign result.pixel_x    = pixel_x_reg;
    assign result.pixel_y    = pixel_y_reg;
    assign result.byte_index = byte_index_reg;
    assign result.bit_number = bit_number_reg;
    assign result.last_pixel = last_reg;
endmodule

### rtl/core/line_pixel_rasterizer_top.sv
// A step transfer shows its pixel on the result channel in the next cycle.
// Throughput: one command per cycle unless a held result stalls in_ready; the
// Bresenham step (one add, compare and increment on the walker registers) and
// the address multiply are combinational. Loads and steps that produce no pixel
// leave nothing on the result channel. Reset (rst_n, async, active low) idles
// the walker, empties the result register and sets the screen to 84 by 48.
module line_pixel_rasterizer_top #(
    parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    lpr_req_if.sink                            request,
    lpr_pix_if.source                          result
);
    import lpr_pkg::*;

    logic [CFG_DATA_BITS-1:0]   width_reg, width_next;
    logic [CFG_DATA_BITS-1:0]   height_reg, height_next;
    logic                       accept;
    logic                       in_ready;
    logic [COORD_BITS-1:0]      cur_x;
    logic [COORD_BITS-1:0]      cur_y;
    step_ctl_t                  ctl;
    logic [PIXEL_X_BITS-1:0]    pixel_x;
    logic [PIXEL_Y_BITS-1:0]    pixel_y;
    logic [BYTE_INDEX_BITS-1:0] byte_index;
    logic [BIT_NUMBER_BITS-1:0] bit_number;

    // Screen size registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_next  = cfg_data;
                CFG_SCREEN_HEIGHT: height_next = cfg_data;
                default:           width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_SCREEN_WIDTH;
            height_reg <= RESET_SCREEN_HEIGHT;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Command transfer
    assign request.ready = in_ready;
    assign accept        = request.valid && in_ready;

    lpr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (request.cmd),
        .start_x (request.start_x),
        .start_y (request.start_y),
        .end_x   (request.end_x),
        .end_y   (request.end_y),
        .cur_x   (cur_x),
        .cur_y   (cur_y),
        .ctl     (ctl)
    );

    lpr_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .cur_x         (cur_x),
        .cur_y         (cur_y),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .byte_index    (byte_index),
        .bit_number    (bit_number)
    );

    lpr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .byte_index (byte_index),
        .bit_number (bit_number),
        .in_ready   (in_ready),
        .result     (result)
    );
endmodule

### sim/line_raster_checker.sv
module line_raster_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    lpr_req_if                                 request,
    lpr_pix_if                                 result,
    output int                                 mismatches,
    output int                                 pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int CW = COORD_BITS_DEFAULT;

    typedef struct packed {
        logic [PIXEL_X_BITS-1:0]    pixel_x;
        logic [PIXEL_Y_BITS-1:0]    pixel_y;
        logic [BYTE_INDEX_BITS-1:0] byte_index;
        logic [BIT_NUMBER_BITS-1:0] bit_number;
        logic                       last_pixel;
    } pixel_t;

    // Pixels predicted from step transfers, oldest first
    pixel_t pixels_due[$];

    // Shadow of the screen registers
    logic [CFG_DATA_BITS-1:0] scr_width;
    logic [CFG_DATA_BITS-1:0] scr_height;

    // Shadow of the line walker
    logic [CW-1:0]     walk_x, walk_y, goal_x, goal_y, dist_x, dist_y;
    logic signed [9:0] bias;
    logic              x_descending, y_descending, x_leads, line_active;

    initial mismatches = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: pixel mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [CW-1:0] clamp_to(input logic [CW-1:0] v,
                                               input logic [CFG_DATA_BITS-1:0] size);
        logic [CW-1:0] lim;
        lim = (size == '0) ? '0 : CW'(size - 1'b1);
        return (v > lim) ? lim : v;
    endfunction

    // Apply one command to the walker shadow; flag a pixel if one comes out
    task automatic rasterize(input logic cmd,
                             input logic [CW-1:0] sx, sy, ex, ey,
                             output logic fired, output pixel_t pix);
        logic [CFG_DATA_BITS-1:0] rows;
        logic [CW-1:0]            cx;
        logic [CW-1:0]            cy;
        logic signed [9:0]        twice_x;
        logic signed [9:0]        twice_y;
        fired = 1'b0;
        pix   = '0;
        if (cmd == CMD_LOAD)
        begin
            walk_x       = sx;
            walk_y       = sy;
            goal_x       = ex;
            goal_y       = ey;
            x_descending = !(ex > sx);
            y_descending = !(ey > sy);
            dist_x       = (ex > sx) ? ex - sx : sx - ex;
            dist_y       = (ey > sy) ? ey - sy : sy - ey;
            x_leads      = dist_x > dist_y;
            if (x_leads)
            begin
                bias        = -$signed({3'b000, dist_x});
                line_active = (sx != ex);
            end
            else
            begin
                bias        = -$signed({3'b000, dist_y});
                line_active = (sy != ey);
            end
        end
        else if (line_active)
        begin
            // Clamp the current point before the walker moves on
            rows    = (scr_height > MAX_SCREEN_HEIGHT) ? MAX_SCREEN_HEIGHT : scr_height;
            cx      = clamp_to(walk_x, scr_width);
            cy      = clamp_to(walk_y, rows);
            twice_x = $signed({2'b00, dist_x, 1'b0});
            twice_y = $signed({2'b00, dist_y, 1'b0});
            if (x_leads)
            begin
                bias = bias + twice_y;
                if (bias > 0)
                begin
                    walk_y = y_descending ? walk_y - 1'b1 : walk_y + 1'b1;
                    bias   = bias - twice_x;
                end
                walk_x      = x_descending ? walk_x - 1'b1 : walk_x + 1'b1;
                line_active = (walk_x != goal_x);
            end
            else
            begin
                bias = bias + twice_x;
                if (bias > 0)
                begin
                    walk_x = x_descending ? walk_x - 1'b1 : walk_x + 1'b1;
                    bias   = bias - twice_y;
                end
                walk_y      = y_descending ? walk_y - 1'b1 : walk_y + 1'b1;
                line_active = (walk_y != goal_y);
            end
            fired          = 1'b1;
            pix.pixel_x    = cx;
            pix.pixel_y    = cy[PIXEL_Y_BITS-1:0];
            pix.byte_index = BYTE_INDEX_BITS'(cx) * BYTE_INDEX_BITS'(rows >> 3)
                             + BYTE_INDEX_BITS'(cy >> 3);
            pix.bit_number = cy[BIT_NUMBER_BITS-1:0];
            pix.last_pixel = !line_active;
        end
    endtask

    // Track config writes, predict on each command transfer, compare each pixel transfer
    always @(posedge clk or negedge rst_n)
    begin
        logic   fired;
        pixel_t pix;
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            scr_width    = RESET_SCREEN_WIDTH;
            scr_height   = RESET_SCREEN_HEIGHT;
            walk_x       = '0;
            walk_y       = '0;
            goal_x       = '0;
            goal_y       = '0;
            dist_x       = '0;
            dist_y       = '0;
            bias         = '0;
            x_descending = 1'b0;
            y_descending = 1'b0;
            x_leads      = 1'b0;
            line_active  = 1'b0;
            pixels_due.delete();
            pixels_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                    scr_width = cfg_data;
                else if (cfg_index == CFG_SCREEN_HEIGHT)
                    scr_height = cfg_data;
            end

            if (result.valid && result.ready)
            begin
                got.pixel_x    = result.pixel_x;
                got.pixel_y    = result.pixel_y;
                got.byte_index = result.byte_index;
                got.bit_number = result.bit_number;
                got.last_pixel = result.last_pixel;
                if (pixels_due.size() == 0)
                    report_mismatch("pixel transfer with none pending", got.pixel_x, -1);
                else
                begin
                    want = pixels_due.pop_front();
                    if (got.pixel_x !== want.pixel_x)
                        report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
                    if (got.pixel_y !== want.pixel_y)
                        report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
                    if (got.byte_index !== want.byte_index)
                        report_mismatch("byte_index", got.byte_index, want.byte_index);
                    if (got.bit_number !== want.bit_number)
                        report_mismatch("bit_number", got.bit_number, want.bit_number);
                    if (got.last_pixel !== want.last_pixel)
                        report_mismatch("last_pixel", got.last_pixel, want.last_pixel);
                end
            end

            if (request.valid && request.ready)
            begin
                rasterize(request.cmd, request.start_x, request.start_y,
                          request.end_x, request.end_y, fired, pix);
                if (fired)
                    pixels_due.push_back(pix);
            end

            pixels_pending = pixels_due.size();
        end
    end
endmodule

### sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int CW              = COORD_BITS_DEFAULT;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 133;
    localparam int HOLD_CYCLES     = 80;

    typedef enum int {SINK_FREE, SINK_COIN, SINK_SLOW, SINK_PERIODIC} sink_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int mismatches;
    int pixels_pending;
    int burst_left   = 0;
    int items_sent   = 0;
    int stall_orders = 0;

    lpr_req_if #(.COORD_BITS(CW)) request_ch();
    lpr_pix_if                    pixel_ch();

    line_pixel_rasterizer_top #(.COORD_BITS(CW)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (pixel_ch)
    );

    line_raster_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .request        (request_ch),
        .result         (pixel_ch),
        .mismatches     (mismatches),
        .pixels_pending (pixels_pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Bound the run
    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Stall the pixel channel on a changing pattern; hold off long when asked
    initial
    begin
        sink_mode_t mode;
        int         seg_left;
        int         hold_left;
        int         stalls_served;
        mode           = SINK_FREE;
        seg_left       = 0;
        hold_left      = 0;
        stalls_served  = 0;
        pixel_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_ch.ready <= 1'b0;
            end
            else if (stall_orders != stalls_served)
            begin
                stalls_served++;
                hold_left = HOLD_CYCLES - 1;
                pixel_ch.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = sink_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(5, 40);
                end
                seg_left--;
                case (mode)
                    SINK_FREE:     pixel_ch.ready <= 1'b1;
                    SINK_COIN:     pixel_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SLOW:     pixel_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:       pixel_ch.ready <= (seg_left % 3 != 0);
                endcase
            end
        end
    end

    function automatic logic [CW-1:0] coord_any();
        return CW'($urandom_range(0, (1 << CW) - 1));
    endfunction

    function automatic logic [CW-1:0] coord_near(input logic [CW-1:0] v);
        int t;
        t = int'(v) + $urandom_range(0, 16) - 8;
        if (t < 0)
            t = 0;
        if (t > (1 << CW) - 1)
            t = (1 << CW) - 1;
        return CW'(t);
    endfunction

    // Offer one command and hold it until the transfer; idle between bursts
    task automatic offer(input logic cmd, input logic [CW-1:0] sx, sy, ex, ey);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                request_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        request_ch.valid   <= 1'b1;
        request_ch.cmd     <= cmd;
        request_ch.start_x <= sx;
        request_ch.start_y <= sy;
        request_ch.end_x   <= ex;
        request_ch.end_y   <= ey;
        @(posedge clk);
        while (!request_ch.ready) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic step_line(input int n);
        repeat (n) offer(CMD_STEP, coord_any(), coord_any(), coord_any(), coord_any());
    endtask

    // Drop valid, wait for every pixel, then let the walker settle
    task automatic drain_and_pause();
        @(negedge clk);
        request_ch.valid <= 1'b0;
        wait (pixels_pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_screen(input logic [CFG_DATA_BITS-1:0] w, h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        logic [CW-1:0] sx, sy, ex, ey;
        int            major, n, pick, lines, phase_base;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_SCREEN_WIDTH;
        cfg_data           = '0;
        request_ch.valid   = 1'b0;
        request_ch.cmd     = CMD_LOAD;
        request_ch.start_x = '0;
        request_ch.start_y = '0;
        request_ch.end_x   = '0;
        request_ch.end_y   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Step with no line loaded
        step_line(1);
        // Zero-length line draws nothing
        offer(CMD_LOAD, 7'd5, 7'd9, 7'd5, 7'd9);
        step_line(1);
        // Shallow x-major line, then one step past its end
        offer(CMD_LOAD, 7'd0, 7'd0, 7'd3, 7'd1);
        step_line(4);
        // Equal spans walk on y, both directions negative, clamped on both axes
        offer(CMD_LOAD, 7'd127, 7'd127, 7'd0, 7'd0);
        step_line(2);
        // Reload while busy drops the current line
        offer(CMD_LOAD, 7'd0, 7'd127, 7'd127, 7'd0);
        step_line(2);
        offer(CMD_LOAD, 7'd127, 7'd0, 7'd0, 7'd127);
        step_line(1);
        // Steep y-major line going left
        offer(CMD_LOAD, 7'd2, 7'd5, 7'd1, 7'd9);
        step_line(4);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_and_pause();
            case (ph)
                0:       set_screen(7'd127, 7'd64);
                1:       set_screen(7'd1, 7'd8);
                2:       set_screen(7'd0, 7'd0);
                3:       set_screen(7'd127, 7'd127);
                4:       set_screen(7'($urandom_range(1, 127)), 7'($urandom_range(1, 8) * 8));
                5:       set_screen(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                default: set_screen(RESET_SCREEN_WIDTH, RESET_SCREEN_HEIGHT);
            endcase
            lines      = 0;
            phase_base = items_sent;
            while (items_sent - phase_base < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: any command with any fields
                    offer(1'($urandom_range(0, 1)), coord_any(), coord_any(),
                          coord_any(), coord_any());
                end
                else
                begin
                    sx = coord_any();
                    sy = coord_any();
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                    begin
                        ex = sx;
                        ey = sy;
                    end
                    else if (pick < 4)
                    begin
                        ex = coord_any();
                        ey = coord_any();
                    end
                    else
                    begin
                        ex = coord_near(sx);
                        ey = coord_near(sy);
                    end
                    major = (ex > sx) ? ex - sx : sx - ex;
                    if (((ey > sy) ? ey - sy : sy - ey) > major)
                        major = (ey > sy) ? ey - sy : sy - ey;
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                        n = major;
                    else if (pick < 17)
                        n = major + $urandom_range(1, 3);
                    else
                        n = (major > 0) ? $urandom_range(0, major - 1) : 1;
                    // Back-pressure the pixel side on the third line; the command side then stalls
                    if (lines == 2)
                    begin
                        stall_orders++;
                        if (n < 20)
                            n = 20;
                    end
                    offer(CMD_LOAD, sx, sy, ex, ey);
                    step_line(n);
                    lines++;
                end
            end
        end

        drain_and_pause();
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
